>>> src/imhq_pkg.sv
// Package for the indexed min-heap queue: sizes, command and status codes,
// item structs and a score clamp function. No dependencies.
package imhq_pkg;
  localparam int unsigned Capacity  = 64;
  localparam int unsigned IdCount   = 64;
  localparam int unsigned ScoreBits = 16;
  localparam int unsigned SlotW     = $clog2(Capacity);
  localparam int unsigned CountW    = $clog2(Capacity + 1);
  localparam int unsigned IdW       = 6;

  localparam logic signed [ScoreBits-1:0] ScoreMax = {1'b0, {(ScoreBits-1){1'b1}}};
  localparam logic signed [ScoreBits-1:0] ScoreMin = {1'b1, {(ScoreBits-1){1'b0}}};

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_ADD    = 3'd2,
    CMD_SUB    = 3'd3,
    CMD_FIND   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_ID   = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_FULL    = 3'd3,
    ST_DUP     = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [IdW-1:0]     entry_id;
    logic signed [15:0] amount;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [IdW-1:0]     result_id;
    logic signed [15:0] result_score;
    logic [5:0]         result_position;
    logic [6:0]         entry_count;
  } rsp_t;

  // one write to the heap store, also updates id table
  typedef struct packed {
    logic                        en;
    logic [SlotW-1:0]            slot;
    logic [IdW-1:0]              id;
    logic signed [ScoreBits-1:0] score;
  } slot_wr_t;

  function automatic logic signed [ScoreBits-1:0] clamp(input logic signed [ScoreBits+1:0] v);
    if (v > $signed({{2{ScoreMax[ScoreBits-1]}}, ScoreMax})) return ScoreMax;
    if (v < $signed({{2{ScoreMin[ScoreBits-1]}}, ScoreMin})) return ScoreMin;
    return v[ScoreBits-1:0];
  endfunction
endpackage

>>> src/imhq_if.sv
// Valid/ready channel interface for the heap queue.
// Depends on imhq_pkg.
interface imhq_req_if import imhq_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface imhq_rsp_if import imhq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/imhq_store.sv
// Heap memories: slot store (id, score) with two read ports, and id-to-slot
// table with one read port. Registered reads. Depends on imhq_pkg.
module imhq_store import imhq_pkg::*; (
  input  logic                        clk_i,
  input  slot_wr_t                    wr_i,
  input  logic [SlotW-1:0]            ra_i,
  input  logic [SlotW-1:0]            rb_i,
  input  logic [IdW-1:0]              rid_i,
  output logic [IdW-1:0]              a_id_o,
  output logic signed [ScoreBits-1:0] a_score_o,
  output logic [IdW-1:0]              b_id_o,
  output logic signed [ScoreBits-1:0] b_score_o,
  output logic [SlotW-1:0]            id_slot_o
);
  logic [IdW-1:0]              sid_mem [Capacity];
  logic signed [ScoreBits-1:0] ssc_mem [Capacity];
  logic [SlotW-1:0]            ids_mem [IdCount];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      sid_mem[wr_i.slot] <= wr_i.id;
      ssc_mem[wr_i.slot] <= wr_i.score;
      ids_mem[wr_i.id]   <= wr_i.slot;
    end
    a_id_o    <= sid_mem[ra_i];
    a_score_o <= ssc_mem[ra_i];
    b_id_o    <= sid_mem[rb_i];
    b_score_o <= ssc_mem[rb_i];
    id_slot_o <= ids_mem[rid_i];
  end
endmodule

>>> src/imhq_ctrl.sv
// Sequencer for insert, remove, adjust and find: reads, compares and writes
// back the heap store one level at a time. Depends on imhq_pkg, imhq_if, imhq_store.
module imhq_ctrl import imhq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  imhq_req_if.sink   req,
  imhq_rsp_if.source rsp
);
  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_ADJ, S_SCORE, S_UPRD, S_UPCMP, S_DNRD, S_DNCMP, S_DONE, S_OUT
  } state_e;

  state_e state_q;
  req_t   req_q;
  logic [CountW-1:0] count_q;
  logic [IdCount-1:0] present_q;
  logic [SlotW-1:0] pos_q;
  logic [IdW-1:0] cid_q;
  logic signed [ScoreBits-1:0] csc_q;
  logic moved_q;
  rsp_t rsp_q;
  logic rsp_v_q;

  slot_wr_t wr;
  logic [SlotW-1:0] ra, rb;
  logic [IdW-1:0] a_id, b_id;
  logic signed [ScoreBits-1:0] a_sc, b_sc;
  logic [SlotW-1:0] id_slot;

  imhq_store u_store (
    .clk_i, .wr_i(wr), .ra_i(ra), .rb_i(rb), .rid_i(req_q.entry_id),
    .a_id_o(a_id), .a_score_o(a_sc), .b_id_o(b_id), .b_score_o(b_sc),
    .id_slot_o(id_slot)
  );

  // child indices of pos_q, wider to test against the count
  logic [SlotW+1:0] lc, rc;
  logic l_ok, r_ok;
  assign lc = {1'b0, pos_q, 1'b1};
  assign rc = {1'b0, pos_q, 1'b0} + (SlotW+2)'(2);
  assign l_ok = lc < (SlotW+2)'(count_q);
  assign r_ok = rc < (SlotW+2)'(count_q);

  logic [SlotW-1:0] parent;
  assign parent = SlotW'((pos_q - SlotW'(1)) >> 1);

  logic [SlotW-1:0] last;
  assign last = SlotW'(count_q - CountW'(1));

  // adjusted score, two guard bits before clamping
  logic signed [ScoreBits+1:0] adj_sum;
  assign adj_sum = (req_q.cmd == CMD_ADD) ?
      (ScoreBits+2)'(a_sc) + (ScoreBits+2)'(req_q.amount) :
      (ScoreBits+2)'(a_sc) - (ScoreBits+2)'(req_q.amount);

  // status decided from presence bits and count
  rsp_t look_rsp;
  logic ins_ok;
  always_comb begin
    look_rsp = '0;
    look_rsp.result_id = req_q.entry_id;
    look_rsp.entry_count = 7'(count_q);
    ins_ok = 1'b0;
    case (req_q.cmd)
      CMD_INSERT: begin
        if (present_q[req_q.entry_id]) look_rsp.status = ST_DUP;
        else if (count_q >= CountW'(Capacity)) look_rsp.status = ST_FULL;
        else begin
          ins_ok = 1'b1;
          look_rsp.entry_count = 7'(count_q + CountW'(1));
        end
      end
      CMD_REMOVE: begin
        look_rsp.result_id = '0;
        if (count_q == '0) look_rsp.status = ST_EMPTY;
      end
      CMD_ADD, CMD_SUB, CMD_FIND: begin
        if (!present_q[req_q.entry_id]) look_rsp.status = ST_NO_ID;
      end
      default: look_rsp.result_id = '0;
    endcase
  end

  always_comb begin
    ra = pos_q;
    rb = pos_q;
    case (state_q)
      S_LOOK:  begin ra = SlotW'(0); rb = last; end
      S_ADJ:   ra = id_slot;
      S_UPRD:  ra = parent;
      S_DNRD:  begin ra = lc[SlotW-1:0]; rb = rc[SlotW-1:0]; end
      default: ;
    endcase
  end

  // sift-down choice
  logic dn_l, dn_r;
  always_comb begin
    dn_l = l_ok && (a_sc < csc_q);
    dn_r = r_ok && (b_sc < (dn_l ? a_sc : csc_q));
  end

  always_comb begin
    wr = '0;
    case (state_q)
      S_UPCMP: begin
        wr.slot = pos_q;
        if (a_sc > csc_q) begin
          wr.en = 1'b1; wr.id = a_id; wr.score = a_sc;
        end
      end
      S_DNCMP: begin
        wr.slot = pos_q;
        if (dn_r) begin
          wr.en = 1'b1; wr.id = b_id; wr.score = b_sc;
        end else if (dn_l) begin
          wr.en = 1'b1; wr.id = a_id; wr.score = a_sc;
        end
      end
      S_DONE: begin
        wr.en = 1'b1; wr.slot = pos_q; wr.id = cid_q; wr.score = csc_q;
      end
      default: ;
    endcase
  end

  assign req.ready = (state_q == S_IDLE) && !rsp_v_q;
  assign rsp.valid = rsp_v_q;
  assign rsp.data  = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      present_q <= '0;
      rsp_v_q   <= 1'b0;
      req_q     <= '0;
      pos_q     <= '0;
      cid_q     <= '0;
      csc_q     <= '0;
      moved_q   <= 1'b0;
      rsp_q     <= '0;
    end else begin
      if (state_q == S_OUT) rsp_v_q <= 1'b1;
      else if (rsp.ready) rsp_v_q <= 1'b0;
      case (state_q)
        S_IDLE: if (req.valid && !rsp_v_q) begin
          req_q   <= req.data;
          state_q <= S_LOOK;
        end
        S_LOOK: begin
          rsp_q <= look_rsp;
          case (req_q.cmd)
            CMD_INSERT: state_q <= !ins_ok ? S_OUT : ((count_q == '0) ? S_DONE : S_UPRD);
            CMD_REMOVE, CMD_ADD, CMD_SUB, CMD_FIND:
              state_q <= (look_rsp.status == ST_OK) ? S_ADJ : S_OUT;
            default: state_q <= S_OUT;
          endcase
          if (ins_ok) begin
            present_q[req_q.entry_id] <= 1'b1;
            pos_q   <= SlotW'(count_q);
            count_q <= count_q + CountW'(1);
            cid_q   <= req_q.entry_id;
            csc_q   <= req_q.amount;
          end
        end
        S_ADJ: begin
          if (req_q.cmd == CMD_REMOVE) begin
            // root and last entry are on ports a and b
            rsp_q <= '{status: ST_OK, result_id: a_id, result_score: a_sc,
                       result_position: '0, entry_count: 7'(count_q - CountW'(1))};
            present_q[a_id] <= 1'b0;
            count_q <= count_q - CountW'(1);
            cid_q <= b_id;
            csc_q <= b_sc;
            pos_q <= '0;
            // a lone entry just leaves
            state_q <= (count_q == CountW'(1)) ? S_OUT : S_DNRD;
          end else begin
            pos_q   <= id_slot;
            state_q <= S_SCORE;
          end
        end
        S_SCORE: begin
          // a_sc is the entry's current score
          moved_q <= 1'b0;
          cid_q   <= req_q.entry_id;
          if (req_q.cmd == CMD_FIND) begin
            rsp_q <= '{status: ST_OK, result_id: req_q.entry_id, result_score: a_sc,
                       result_position: pos_q, entry_count: rsp_q.entry_count};
            state_q <= S_OUT;
          end else begin
            csc_q   <= clamp(adj_sum);
            state_q <= (pos_q == '0) ? S_DNRD : S_UPRD;
          end
        end
        S_UPRD: state_q <= S_UPCMP;
        S_UPCMP: begin
          if (a_sc > csc_q) begin
            pos_q   <= parent;
            moved_q <= 1'b1;
            state_q <= (parent == '0) ? S_DONE : S_UPRD;
          end else begin
            // an entry that rose cannot sink
            state_q <= (req_q.cmd == CMD_INSERT || moved_q) ? S_DONE : S_DNRD;
          end
        end
        S_DNRD: state_q <= l_ok ? S_DNCMP : S_DONE;
        S_DNCMP: begin
          if (dn_r) begin pos_q <= rc[SlotW-1:0]; state_q <= S_DNRD; end
          else if (dn_l) begin pos_q <= lc[SlotW-1:0]; state_q <= S_DNRD; end
          else state_q <= S_DONE;
        end
        S_DONE: begin
          if (req_q.cmd != CMD_REMOVE) begin
            rsp_q <= '{status: rsp_q.status, result_id: rsp_q.result_id,
                       result_score: csc_q, result_position: pos_q,
                       entry_count: rsp_q.entry_count};
          end
          state_q <= S_OUT;
        end
        S_OUT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

>>> src/indexed_min_heap_queue_top.sv
// Indexed min-heap queue top level.
// Item channel req (cmd, entry_id, amount) and result channel rsp, both
// valid/ready; an item moves when valid and ready are high at a clock edge.
// The heap of (id, score) pairs lives in a dual-read slot memory and an
// id-to-slot memory, both with registered reads; presence bits and the
// count are flip-flops.
// One item is handled at a time. Errors and unknown commands go from the
// lookup straight to the output register; find first reads the id table
// and then the slot store; an insert into an empty heap writes its slot
// directly; insert, remove and adjust sift one heap level at a time, with
// a read step and then a compare and write-back step for each level.
// The next item is taken the cycle after the result has left the output
// register; a stalled receiver holds the result and the block waits.
// Reset clears the presence bits, the count and the control state; the
// memories are not cleared and need no sweep.
module indexed_min_heap_queue_top import imhq_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  imhq_req_if.sink   req,
  imhq_rsp_if.source rsp
);
  imhq_ctrl u_ctrl (.clk_i, .rst_ni, .req, .rsp);

  a_ok_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.data.status == ST_OK && rsp.data.entry_count != '0 |->
      7'(rsp.data.result_position) < rsp.data.entry_count ||
      rsp.data.result_position == '0)
    else $error("position beyond count");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> rsp.data.entry_count <= 7'(Capacity))
    else $error("count overflow");
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !req.ready)
    else $error("item accepted with result pending");
endmodule
